/* rtl/a2l_pkg.sv */
// ----------------------------------------------------------------------------
// a2l_pkg
// Shared constants and types for the address-to-line lookup block: table
// geometry, field widths, request and register codes, table entry layout.
// ----------------------------------------------------------------------------
`default_nettype none

package a2l_pkg;

   // Table geometry: real entries plus one sentinel slot
   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH + 1);
   localparam int SW          = IDX_W + 1;          // signed search bounds

   localparam logic [IDX_W:0] DEPTH_X = (IDX_W + 1)'(TABLE_DEPTH);

   // Port field widths
   localparam int REQ_W      = 2;
   localparam int EIDX_W     = 11;
   localparam int ADDR_W     = 32;
   localparam int LINE_W     = 24;
   localparam int SLIDE_W    = 2;
   localparam int OLINE_W    = 25;
   localparam int COUNT_W    = 11;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd1;
   localparam logic [REQ_W-1:0] REQ_NEXT   = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TABLE_VALID = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_BASE   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_END_MARKER  = 2'd3;

   localparam logic [LINE_W-1:0] END_MARKER_RST = {LINE_W{1'b1}};

   // Line code for "no next statement"
   localparam logic [OLINE_W-1:0] LINE_NO_NEXT = {OLINE_W{1'b1}};

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [LINE_W-1:0] line;
   } entry_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
      entry_type         data;
   } mem_wr_type;

   typedef struct packed {
      logic              en;
      logic [IDX_W-1:0]  idx;
   } mem_rd_type;

   typedef struct packed {
      logic               table_valid;
      logic [COUNT_W-1:0] entry_count;
      logic [ADDR_W-1:0]  address_base;
      logic [LINE_W-1:0]  end_marker;
   } cfg_type;

endpackage

`default_nettype wire

/* rtl/address_to_line_lookup.sv */
// ----------------------------------------------------------------------------
// address_to_line_lookup
// Address-to-line table with binary search lookup, slide to neighbouring
// entry on a miss, and a cursor that steps to the next statement.
//
//   Channel   Ports                          Transfer when
//   request   start/busy, req_*              start & !busy
//   result    rsp_valid, rsp_*               rsp_valid (one cycle strobe)
//   config    csr_valid/csr_ready, csr_*     csr_valid & csr_ready
//
// Load: busy stays low. Lookup: P probes (at most 11 over the 1025-entry
// window), one per cycle through the single table read port, then a decide
// step; the result strobe follows it on a miss, else follows the entry fetch,
// and then the neighbour fetch when there is a neighbour entry for the span.
// Next: entry fetch, then neighbour fetch, skipped at the end marker or the
// last slot. Empty-table, no-cursor and past-storage answers come the cycle after transfer.
// Reset clears cursor (entry 0, valid) and registers; table contents are
// undefined until loaded. Results cannot be stalled; a new request is taken
// in the cycle a result is shown.
// ----------------------------------------------------------------------------
`default_nettype none

module address_to_line_lookup (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire [a2l_pkg::REQ_W-1:0]             req_type,
   input  wire [a2l_pkg::EIDX_W-1:0]            req_entry_index,
   input  wire [a2l_pkg::ADDR_W-1:0]            req_entry_address,
   input  wire [a2l_pkg::LINE_W-1:0]            req_entry_line,
   input  wire [a2l_pkg::ADDR_W-1:0]            req_query_pc,
   input  wire signed [a2l_pkg::SLIDE_W-1:0]    req_slide_mode,
   output logic                                 rsp_valid,
   output logic signed [a2l_pkg::OLINE_W-1:0]   rsp_line_number,
   output logic [a2l_pkg::ADDR_W-1:0]           rsp_statement_address,
   output logic [a2l_pkg::ADDR_W-1:0]           rsp_span_bytes,
   input  wire                                  csr_valid,
   output logic                                 csr_ready,
   input  wire [a2l_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire [a2l_pkg::CSR_DATA_W-1:0]        csr_data
);
   import a2l_pkg::*;

   cfg_type     cfg;
   mem_wr_type  mem_wr;
   mem_rd_type  mem_rd;
   entry_type   mem_rdata;

   a2l_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   a2l_table_mem u_mem (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (mem_rdata)
   );

   a2l_ctrl u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_type              (req_type),
      .req_entry_index       (req_entry_index),
      .req_entry_address     (req_entry_address),
      .req_entry_line        (req_entry_line),
      .req_query_pc          (req_query_pc),
      .req_slide_mode        (req_slide_mode),
      .rsp_valid             (rsp_valid),
      .rsp_line_number       (rsp_line_number),
      .rsp_statement_address (rsp_statement_address),
      .rsp_span_bytes        (rsp_span_bytes),
      .cfg                   (cfg),
      .mem_wr                (mem_wr),
      .mem_rd                (mem_rd),
      .mem_rdata             (mem_rdata)
   );

endmodule

`default_nettype wire

/* rtl/a2l_table_mem.sv */
// ----------------------------------------------------------------------------
// a2l_table_mem
// Line table storage: one write port, one read port, registered read data.
// Holds address and line of each entry in a single word.
// ----------------------------------------------------------------------------
`default_nettype none

module a2l_table_mem (
   input  wire                  clock,
   input  a2l_pkg::mem_wr_type  wr,
   input  a2l_pkg::mem_rd_type  rd,
   output a2l_pkg::entry_type   rd_data
);
   import a2l_pkg::*;

   entry_type mem [0:TABLE_DEPTH];
   entry_type rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.idx] <= wr.data;
      end
   end

   // Read port, registered read data
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rdata_ff <= mem[rd.idx];
      end
   end

   assign rd_data = rdata_ff;

endmodule

`default_nettype wire

/* rtl/a2l_csr.sv */
// ----------------------------------------------------------------------------
// a2l_csr
// Configuration registers: table present flag, entry count, load base and
// end-of-table line marker.
// ----------------------------------------------------------------------------
`default_nettype none

module a2l_csr (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire [a2l_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [a2l_pkg::CSR_DATA_W-1:0]      csr_data,
   output a2l_pkg::cfg_type                   cfg
);
   import a2l_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register writes are always accepted
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_TABLE_VALID: cfg_in.table_valid  = csr_data[0];
            CSR_ENTRY_COUNT: cfg_in.entry_count  = csr_data[COUNT_W-1:0];
            CSR_ADDR_BASE:   cfg_in.address_base = csr_data[ADDR_W-1:0];
            CSR_END_MARKER:  cfg_in.end_marker   = csr_data[LINE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.table_valid  <= 1'b0;
         cfg_ff.entry_count  <= '0;
         cfg_ff.address_base <= '0;
         cfg_ff.end_marker   <= END_MARKER_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/a2l_ctrl.sv */
// ----------------------------------------------------------------------------
// a2l_ctrl
// Request sequencer: table loads, binary search probing one entry per
// cycle, neighbour fetch for the span, cursor stepping and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module a2l_ctrl (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  start,
   output logic                                 busy,
   input  wire [a2l_pkg::REQ_W-1:0]             req_type,
   input  wire [a2l_pkg::EIDX_W-1:0]            req_entry_index,
   input  wire [a2l_pkg::ADDR_W-1:0]            req_entry_address,
   input  wire [a2l_pkg::LINE_W-1:0]            req_entry_line,
   input  wire [a2l_pkg::ADDR_W-1:0]            req_query_pc,
   input  wire signed [a2l_pkg::SLIDE_W-1:0]    req_slide_mode,
   output logic                                 rsp_valid,
   output logic signed [a2l_pkg::OLINE_W-1:0]   rsp_line_number,
   output logic [a2l_pkg::ADDR_W-1:0]           rsp_statement_address,
   output logic [a2l_pkg::ADDR_W-1:0]           rsp_span_bytes,
   input  a2l_pkg::cfg_type                     cfg,
   output a2l_pkg::mem_wr_type                  mem_wr,
   output a2l_pkg::mem_rd_type                  mem_rd,
   input  a2l_pkg::entry_type                   mem_rdata
);
   import a2l_pkg::*;

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_SEARCH = 3'd1;
   localparam logic [2:0] S_DECIDE = 3'd2;
   localparam logic [2:0] S_LK_ENT = 3'd3;
   localparam logic [2:0] S_NX_ENT = 3'd4;
   localparam logic [2:0] S_NBR    = 3'd5;

   logic [2:0]               state_ff,     state_in;
   logic [ADDR_W-1:0]        ref_ff,       ref_in;      // rebased pc or entry addr
   logic                     below_ff,     below_in;
   logic                     above_ff,     above_in;
   logic [IDX_W-1:0]         count_ff,     count_in;
   logic signed [SW-1:0]     first_ff,     first_in;
   logic signed [SW-1:0]     last_ff,      last_in;
   logic [IDX_W-1:0]         mid_ff,       mid_in;
   logic                     found_ff,     found_in;
   logic [IDX_W-1:0]         nb_idx_ff,    nb_idx_in;
   logic                     need_nb_ff,   need_nb_in;
   logic                     rev_ff,       rev_in;
   logic [ADDR_W-1:0]        addr_e_ff,    addr_e_in;
   logic [LINE_W-1:0]        line_e_ff,    line_e_in;
   logic [IDX_W-1:0]         cursor_ff,    cursor_in;
   logic                     cursor_vld_ff, cursor_vld_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OLINE_W-1:0]       rsp_line_ff,  rsp_line_in;
   logic [ADDR_W-1:0]        rsp_addr_ff,  rsp_addr_in;
   logic [ADDR_W-1:0]        rsp_span_ff,  rsp_span_in;

   logic                     accept;
   logic [IDX_W-1:0]         count_sat;
   logic [IDX_W:0]           cur_p1;
   logic [IDX_W:0]           mid_p1;
   logic signed [SW-1:0]     count_s;
   logic signed [SW-1:0]     first_n;
   logic signed [SW-1:0]     last_n;
   logic [SW:0]              sum_n;
   logic                     cond_n;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Table load: single write, no result
   always_comb begin
      mem_wr.en   = accept && (req_type == REQ_LOAD) &&
                    ((IDX_W + 1)'(req_entry_index) <= DEPTH_X);
      mem_wr.idx  = req_entry_index[IDX_W-1:0];
      mem_wr.data = '{addr: req_entry_address, line: req_entry_line};
   end

   // Shared arithmetic
   assign count_sat = (cfg.entry_count > COUNT_W'(TABLE_DEPTH)) ?
                      IDX_W'(TABLE_DEPTH) : IDX_W'(cfg.entry_count);
   assign cur_p1    = {1'b0, cursor_ff} + (IDX_W + 1)'(1);
   assign mid_p1    = {1'b0, mid_ff} + (IDX_W + 1)'(1);
   assign count_s   = $signed({1'b0, count_ff});

   // Search step: narrow the window from the probed entry
   always_comb begin
      first_n = first_ff;
      last_n  = last_ff;
      if (mem_rdata.addr > ref_ff) begin
         last_n = $signed({1'b0, mid_ff}) - $signed(SW'(1));
      end else begin
         first_n = $signed({1'b0, mid_ff}) + $signed(SW'(1));
      end
      cond_n = (first_n <= last_n) && (last_n != '0);
      sum_n  = {1'b0, first_n} + {1'b0, last_n};
   end

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      ref_in        = ref_ff;
      below_in      = below_ff;
      above_in      = above_ff;
      count_in      = count_ff;
      first_in      = first_ff;
      last_in       = last_ff;
      mid_in        = mid_ff;
      found_in      = found_ff;
      nb_idx_in     = nb_idx_ff;
      need_nb_in    = need_nb_ff;
      rev_in        = rev_ff;
      addr_e_in     = addr_e_ff;
      line_e_in     = line_e_ff;
      cursor_in     = cursor_ff;
      cursor_vld_in = cursor_vld_ff;
      rsp_valid_in  = 1'b0;
      rsp_line_in   = rsp_line_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_span_in   = rsp_span_ff;
      mem_rd.en     = 1'b0;
      mem_rd.idx    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_type)
                  REQ_LOOKUP: begin
                     if (!cfg.table_valid) begin
                        rsp_valid_in = 1'b1;
                        rsp_line_in  = '0;
                        rsp_addr_in  = '0;
                        rsp_span_in  = '0;
                     end else begin
                        count_in = count_sat;
                        ref_in   = req_query_pc - cfg.address_base;
                        below_in = req_slide_mode[1];
                        above_in = !req_slide_mode[1] && req_slide_mode[0];
                        first_in = '0;
                        last_in  = $signed({1'b0, count_sat});
                        found_in = 1'b0;
                        mid_in   = {1'b0, count_sat[IDX_W-1:1]};
                        if (count_sat != '0) begin
                           mem_rd.en  = 1'b1;
                           mem_rd.idx = {1'b0, count_sat[IDX_W-1:1]};
                           state_in   = S_SEARCH;
                        end else begin
                           state_in   = S_DECIDE;
                        end
                     end
                  end
                  REQ_NEXT: begin
                     if (!cfg.table_valid || !cursor_vld_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_line_in  = LINE_NO_NEXT;
                        rsp_addr_in  = '0;
                        rsp_span_in  = '0;
                     end else if (cur_p1 > DEPTH_X) begin
                        rsp_valid_in  = 1'b1;
                        rsp_line_in   = LINE_NO_NEXT;
                        rsp_addr_in   = '0;
                        rsp_span_in   = '0;
                        cursor_vld_in = 1'b0;
                     end else begin
                        cursor_in  = cur_p1[IDX_W-1:0];
                        mem_rd.en  = 1'b1;
                        mem_rd.idx = cur_p1[IDX_W-1:0];
                        state_in   = S_NX_ENT;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end

         // One probe per cycle; read data belongs to mid_ff
         S_SEARCH: begin
            if (mem_rdata.addr == ref_ff) begin
               found_in = 1'b1;
               state_in = S_DECIDE;
            end else begin
               first_in = first_n;
               last_in  = last_n;
               if (cond_n) begin
                  mid_in     = sum_n[IDX_W:1];
                  mem_rd.en  = 1'b1;
                  mem_rd.idx = sum_n[IDX_W:1];
               end else begin
                  state_in = S_DECIDE;
               end
            end
         end

         // Pick exact hit, entry below, entry above or miss
         S_DECIDE: begin
            priority if (found_ff) begin
               cursor_in  = mid_ff;
               nb_idx_in  = mid_p1[IDX_W-1:0];
               need_nb_in = (mid_p1 <= {1'b0, count_ff});
               rev_in     = 1'b0;
            end else if (below_ff && (first_ff < count_s) && !last_ff[SW-1]) begin
               cursor_in  = last_ff[IDX_W-1:0];
               nb_idx_in  = last_ff[IDX_W-1:0] + IDX_W'(1);
               need_nb_in = 1'b1;
               rev_in     = 1'b0;
            end else if (above_ff && (first_ff < count_s)) begin
               cursor_in  = first_ff[IDX_W-1:0];
               nb_idx_in  = first_ff[IDX_W-1:0] - IDX_W'(1);
               need_nb_in = (first_ff != '0);
               rev_in     = 1'b1;
            end else begin
               cursor_in  = cursor_ff;
            end
            if (found_ff || (below_ff && (first_ff < count_s) && !last_ff[SW-1]) ||
                (above_ff && (first_ff < count_s))) begin
               cursor_vld_in = 1'b1;
               mem_rd.en     = 1'b1;
               mem_rd.idx    = cursor_in;
               state_in      = S_LK_ENT;
            end else begin
               cursor_vld_in = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_line_in   = '0;
               rsp_addr_in   = '0;
               rsp_span_in   = '0;
               state_in      = S_IDLE;
            end
         end

         // Chosen lookup entry arrives
         S_LK_ENT: begin
            addr_e_in = mem_rdata.addr;
            line_e_in = mem_rdata.line;
            if (need_nb_ff) begin
               mem_rd.en  = 1'b1;
               mem_rd.idx = nb_idx_ff;
               state_in   = S_NBR;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_line_in  = {1'b0, mem_rdata.line};
               rsp_addr_in  = mem_rdata.addr + cfg.address_base;
               rsp_span_in  = '0;
               state_in     = S_IDLE;
            end
         end

         // Stepped cursor entry arrives
         S_NX_ENT: begin
            addr_e_in = mem_rdata.addr;
            line_e_in = mem_rdata.line;
            if (mem_rdata.line != cfg.end_marker) begin
               ref_in = mem_rdata.addr;
               rev_in = 1'b0;
               if (cur_p1 <= DEPTH_X) begin
                  mem_rd.en  = 1'b1;
                  mem_rd.idx = cur_p1[IDX_W-1:0];
                  state_in   = S_NBR;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_line_in  = {1'b0, mem_rdata.line};
                  rsp_addr_in  = mem_rdata.addr + cfg.address_base;
                  rsp_span_in  = '0;
                  state_in     = S_IDLE;
               end
            end else begin
               cursor_vld_in = 1'b0;
               rsp_valid_in  = 1'b1;
               rsp_line_in   = LINE_NO_NEXT;
               rsp_addr_in   = mem_rdata.addr + cfg.address_base;
               rsp_span_in   = '0;
               state_in      = S_IDLE;
            end
         end

         // Neighbour entry arrives: span and result
         S_NBR: begin
            rsp_valid_in = 1'b1;
            rsp_line_in  = {1'b0, line_e_ff};
            rsp_addr_in  = addr_e_ff + cfg.address_base;
            rsp_span_in  = rev_ff ? (ref_ff - mem_rdata.addr) : (mem_rdata.addr - ref_ff);
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         cursor_ff     <= '0;
         cursor_vld_ff <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_ff     <= cursor_in;
         cursor_vld_ff <= cursor_vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      ref_ff      <= ref_in;
      below_ff    <= below_in;
      above_ff    <= above_in;
      count_ff    <= count_in;
      first_ff    <= first_in;
      last_ff     <= last_in;
      mid_ff      <= mid_in;
      found_ff    <= found_in;
      nb_idx_ff   <= nb_idx_in;
      need_nb_ff  <= need_nb_in;
      rev_ff      <= rev_in;
      addr_e_ff   <= addr_e_in;
      line_e_ff   <= line_e_in;
      rsp_line_ff <= rsp_line_in;
      rsp_addr_ff <= rsp_addr_in;
      rsp_span_ff <= rsp_span_in;
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_line_number       = $signed(rsp_line_ff);
   assign rsp_statement_address = rsp_addr_ff;
   assign rsp_span_bytes        = rsp_span_ff;

`ifndef SYNTHESIS
   // Probe window stays inside the table while searching
   a_search_window: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (!first_ff[SW-1] && (first_ff <= last_ff) &&
                                  (last_ff != '0) && (last_ff <= count_s)))
      else $error("search window out of bounds");

   a_search_mid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SEARCH) |-> (mid_ff <= count_ff))
      else $error("probe index beyond entry count");

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      cursor_vld_ff |-> ({1'b0, cursor_ff} <= DEPTH_X))
      else $error("cursor beyond table");

   a_nbr_result: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NBR) |=> (rsp_valid_ff && (state_ff == S_IDLE)))
      else $error("neighbour fetch gave no result");

   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_type == REQ_LOOKUP) && cfg.table_valid) |=> (busy && !rsp_valid_ff))
      else $error("lookup did not start a search");
`endif

endmodule

`default_nettype wire

/* sim/tb_address_to_line_lookup.sv */
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb_address_to_line_lookup
// Self-checking bench for the address-to-line lookup block. Loads sorted line
// tables (one full-depth table, then many short ones), runs directed and
// random address lookups and next-statement walks under several register
// settings, and checks every result against an in-bench copy of the table,
// the binary search and the cursor.
// ----------------------------------------------------------------------------
module tb_address_to_line_lookup;
   import a2l_pkg::*;

   localparam int TOTAL_ITEMS    = 1850;
   localparam int SETTLE_CYCLES  = 24;
   localparam int WATCHDOG_LIMIT = 2000;

   // request code the block ignores, slide codes
   localparam logic [REQ_W-1:0]   REQ_UNUSED     = 2'd3;
   localparam logic [SLIDE_W-1:0] SLIDE_NONE     = 2'b00;
   localparam logic [SLIDE_W-1:0] SLIDE_UP       = 2'b01;
   localparam logic [SLIDE_W-1:0] SLIDE_DOWN     = 2'b11;
   localparam logic [SLIDE_W-1:0] SLIDE_DOWN_FAR = 2'b10;

   typedef struct packed {
      logic [REQ_W-1:0]   kind;
      logic [EIDX_W-1:0]  index;
      logic [ADDR_W-1:0]  address;
      logic [LINE_W-1:0]  line;
      logic [ADDR_W-1:0]  pc;
      logic [SLIDE_W-1:0] slide;
   } line_req_type;

   typedef struct packed {
      logic [OLINE_W-1:0] line;
      logic [ADDR_W-1:0]  address;
      logic [ADDR_W-1:0]  span;
   } line_answer_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [REQ_W-1:0]             req_type = REQ_LOAD;
   logic [EIDX_W-1:0]            req_entry_index = '0;
   logic [ADDR_W-1:0]            req_entry_address = '0;
   logic [LINE_W-1:0]            req_entry_line = '0;
   logic [ADDR_W-1:0]            req_query_pc = '0;
   logic signed [SLIDE_W-1:0]    req_slide_mode = '0;
   logic                         rsp_valid;
   logic signed [OLINE_W-1:0]    rsp_line_number;
   logic [ADDR_W-1:0]            rsp_statement_address;
   logic [ADDR_W-1:0]            rsp_span_bytes;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CSR_IDX_W-1:0]         csr_index = '0;
   logic [CSR_DATA_W-1:0]        csr_data = '0;

   // shadow of the line table, cursor and registers
   logic [ADDR_W-1:0]  shadow_addr [0:TABLE_DEPTH];
   logic [LINE_W-1:0]  shadow_line [0:TABLE_DEPTH];
   int                 cursor_at;
   bit                 cursor_live;
   bit                 tbl_present;
   logic [COUNT_W-1:0] tbl_count;
   logic [ADDR_W-1:0]  load_base;
   logic [LINE_W-1:0]  end_marker;

   line_answer_type    pending_answers [$];
   int                 mismatch_count = 0;
   int                 quiet_cycles = 0;
   int                 items_sent = 0;
   bit                 gaps_on = 1'b1;

   address_to_line_lookup dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_type              (req_type),
      .req_entry_index       (req_entry_index),
      .req_entry_address     (req_entry_address),
      .req_entry_line        (req_entry_line),
      .req_query_pc          (req_query_pc),
      .req_slide_mode        (req_slide_mode),
      .rsp_valid             (rsp_valid),
      .rsp_line_number       (rsp_line_number),
      .rsp_statement_address (rsp_statement_address),
      .rsp_span_bytes        (rsp_span_bytes),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Expected answer for one request; updates the shadow state.
   // Returns 1 when the request produces a result.
   function automatic bit resolve_line(input line_req_type r, output line_answer_type ans);
      int               first, last, mid, cnt, idx;
      bit               hit;
      logic [ADDR_W-1:0] off;
      ans = '0;
      case (r.kind)
         REQ_LOAD: begin
            if (r.index <= TABLE_DEPTH) begin
               shadow_addr[r.index] = r.address;
               shadow_line[r.index] = r.line;
            end
            return 1'b0;
         end
         REQ_LOOKUP: begin
            if (!tbl_present)
               return 1'b1;
            cnt   = (tbl_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(tbl_count);
            off   = r.pc - load_base;
            first = 0;
            last  = cnt;
            mid   = 0;
            hit   = 1'b0;
            while (first <= last && last != 0 && !hit) begin
               mid = (first + last) / 2;
               if (shadow_addr[mid] == off)
                  hit = 1'b1;
               else if (shadow_addr[mid] > off)
                  last = mid - 1;
               else
                  first = mid + 1;
            end
            if (hit) begin
               ans.line    = {1'b0, shadow_line[mid]};
               ans.address = shadow_addr[mid] + load_base;
               ans.span    = (mid + 1 <= cnt) ? shadow_addr[mid + 1] - off : '0;
               cursor_at   = mid;
               cursor_live = 1'b1;
            end else if (r.slide[SLIDE_W-1] && first < cnt && last >= 0) begin
               // slide to the entry below
               ans.line    = {1'b0, shadow_line[last]};
               ans.address = shadow_addr[last] + load_base;
               ans.span    = shadow_addr[last + 1] - off;
               cursor_at   = last;
               cursor_live = 1'b1;
            end else if (r.slide == SLIDE_UP && first < cnt) begin
               // slide to the entry above
               ans.line    = {1'b0, shadow_line[first]};
               ans.address = shadow_addr[first] + load_base;
               ans.span    = (first >= 1) ? off - shadow_addr[first - 1] : '0;
               cursor_at   = first;
               cursor_live = 1'b1;
            end else begin
               cursor_live = 1'b0;
            end
            return 1'b1;
         end
         REQ_NEXT: begin
            ans.line = LINE_NO_NEXT;
            if (!tbl_present || !cursor_live)
               return 1'b1;
            idx = cursor_at + 1;
            if (idx > TABLE_DEPTH) begin
               cursor_live = 1'b0;
               return 1'b1;
            end
            cursor_at = idx;
            if (shadow_line[idx] != end_marker) begin
               ans.line    = {1'b0, shadow_line[idx]};
               ans.address = shadow_addr[idx] + load_base;
               ans.span    = (idx + 1 <= TABLE_DEPTH) ? shadow_addr[idx + 1] - shadow_addr[idx] : '0;
            end else begin
               // end marker: report the marker entry's address, cursor is gone
               ans.address = shadow_addr[idx] + load_base;
               cursor_live = 1'b0;
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   // Request with every field randomized; callers override what matters
   function automatic line_req_type any_item(input logic [REQ_W-1:0] kind);
      line_req_type r;
      r.kind    = kind;
      r.index   = EIDX_W'($urandom);
      r.address = $urandom;
      r.line    = LINE_W'($urandom);
      r.pc      = $urandom;
      r.slide   = SLIDE_W'($urandom);
      return r;
   endfunction

   // Start stays high across back-to-back items; only a gap or a drain lowers it
   task automatic idle_gap();
      int n, roll;
      n = 0;
      if (gaps_on) begin
         roll = $urandom_range(0, 99);
         if (roll < 55)
            n = 0;
         else if (roll < 90)
            n = $urandom_range(1, 3);
         else if (roll < 98)
            n = $urandom_range(4, 9);
         else
            n = $urandom_range(10, 40);
      end
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   // One request transfer; the expected answer is queued once the block is no longer busy
   task automatic send_item(input line_req_type r);
      line_answer_type ans;
      idle_gap();
      start             <= 1'b1;
      req_type          <= r.kind;
      req_entry_index   <= r.index;
      req_entry_address <= r.address;
      req_entry_line    <= r.line;
      req_query_pc      <= r.pc;
      req_slide_mode    <= r.slide;
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent++;
      if (resolve_line(r, ans))
         pending_answers.push_back(ans);
   endtask

   task automatic send_lookup(input logic [ADDR_W-1:0] pc, input logic [SLIDE_W-1:0] slide);
      line_req_type r;
      r       = any_item(REQ_LOOKUP);
      r.pc    = pc;
      r.slide = slide;
      send_item(r);
   endtask

   task automatic send_next();
      send_item(any_item(REQ_NEXT));
   endtask

   task automatic send_load(input logic [EIDX_W-1:0] idx, input logic [ADDR_W-1:0] a,
                            input logic [LINE_W-1:0] ln);
      line_req_type r;
      r         = any_item(REQ_LOAD);
      r.index   = idx;
      r.address = a;
      r.line    = ln;
      send_item(r);
   endtask

   task automatic send_unused();
      send_item(any_item(REQ_UNUSED));
   endtask

   // Requests the block drops: unused code or a load past the table
   task automatic send_noise();
      if ($urandom_range(0, 1))
         send_unused();
      else
         send_load(EIDX_W'($urandom_range(TABLE_DEPTH + 1, 2047)), $urandom, LINE_W'($urandom));
   endtask

   // Hold the sender until every result is back, then let loads settle
   task automatic drain_results();
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_TABLE_VALID: tbl_present = data[0];
         CSR_ENTRY_COUNT: tbl_count   = data[COUNT_W-1:0];
         CSR_ADDR_BASE:   load_base   = data;
         CSR_END_MARKER:  end_marker  = data[LINE_W-1:0];
         default: ;
      endcase
   endtask

   // All four registers; unused upper data bits carry junk
   task automatic program_table(input bit present, input logic [COUNT_W-1:0] count,
                                input logic [ADDR_W-1:0] base, input logic [LINE_W-1:0] marker);
      logic [CSR_DATA_W-1:0] junk;
      junk = $urandom;
      write_reg(CSR_TABLE_VALID, {junk[CSR_DATA_W-1:1], present});
      write_reg(CSR_ENTRY_COUNT, {junk[CSR_DATA_W-1:COUNT_W], count});
      write_reg(CSR_ADDR_BASE, base);
      write_reg(CSR_END_MARKER, {junk[CSR_DATA_W-1:LINE_W], marker});
      csr_valid <= 1'b0;
   endtask

   // Sorted entries 0..n-1 plus the sentinel at n, with dropped requests mixed in
   task automatic load_sorted_table(input int n, input logic [LINE_W-1:0] marker,
                                    input logic [ADDR_W-1:0] first_addr, input bit with_dups);
      logic [ADDR_W-1:0] a;
      logic [LINE_W-1:0] ln;
      int                roll;
      a = first_addr;
      for (int i = 0; i <= n; i++) begin
         if ($urandom_range(0, 24) == 0)
            send_noise();
         roll = $urandom_range(0, 99);
         if (i == n)
            ln = marker;
         else if (roll < 2)
            ln = marker;                    // early end of the walk
         else if (roll < 4)
            ln = '0;
         else
            do ln = LINE_W'($urandom); while (ln == marker);
         send_load(EIDX_W'(i), a, ln);
         roll = $urandom_range(0, 19);
         if (roll == 0 && with_dups)
            a = a;
         else if (roll < 16)
            a = a + $urandom_range(1, 64);
         else
            a = a + $urandom_range(1, 1 << 20);
      end
   endtask

   // Lookups near table entries and at random or extreme pcs, next-statement walks, stray loads and noise
   task automatic random_queries(input int n, input int total);
      int                j, pick;
      logic [ADDR_W-1:0] pc;
      for (int k = 0; k < total; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            j = $urandom_range(0, n);
            case ($urandom_range(0, 5))
               0, 1:    pc = shadow_addr[j] + load_base;
               2:       pc = shadow_addr[j] + load_base + 1;
               3:       pc = shadow_addr[j] + load_base - 1;
               4:       pc = $urandom;
               default: pc = $urandom_range(0, 1) ? '1 : '0;
            endcase
            send_lookup(pc, SLIDE_W'($urandom));
         end else if (pick < 92) begin
            send_next();
         end else if (pick < 95) begin
            send_load(EIDX_W'($urandom_range(0, TABLE_DEPTH)), $urandom, LINE_W'($urandom));
         end else begin
            send_noise();
         end
      end
   endtask

   // No table present after reset: empty answers, dropped requests
   task automatic test_empty_table();
      gaps_on = 1'b1;
      send_lookup('0, SLIDE_NONE);
      send_lookup('1, SLIDE_DOWN);
      send_lookup($urandom, SLIDE_UP);
      send_next();
      send_unused();
      send_load(EIDX_W'(TABLE_DEPTH + 1), '1, '1);
      send_load('1, '0, '0);
   endtask

   // Full-depth table, count register above the depth (saturates)
   task automatic test_full_table();
      logic [ADDR_W-1:0] mid_pc;
      drain_results();
      program_table(1'b1, '1, 32'h8000_0000, END_MARKER_RST);
      load_sorted_table(TABLE_DEPTH, END_MARKER_RST, 32'h0000_0100, 1'b0);
      // at and below entry 0
      send_lookup(shadow_addr[0] + load_base, SLIDE_NONE);
      send_lookup(shadow_addr[0] + load_base - 1, SLIDE_DOWN);
      send_lookup(shadow_addr[0] + load_base - 1, SLIDE_UP);
      // between two entries: miss, then both slide directions
      mid_pc = shadow_addr[5] + load_base + 1;
      send_lookup(mid_pc, SLIDE_NONE);
      send_next();
      send_lookup(mid_pc, SLIDE_DOWN);
      send_next();
      send_lookup(mid_pc, SLIDE_DOWN_FAR);
      send_lookup(mid_pc, SLIDE_UP);
      // walk onto the end marker
      send_lookup(shadow_addr[TABLE_DEPTH - 1] + load_base, SLIDE_NONE);
      send_next();
      // above the sentinel
      send_lookup(shadow_addr[TABLE_DEPTH] + load_base + 1, SLIDE_UP);
      send_lookup(shadow_addr[TABLE_DEPTH] + load_base + 1, SLIDE_DOWN);
   endtask

   // Last storage slot without the marker line: next runs off the storage
   task automatic test_past_storage();
      logic [LINE_W-1:0] marker;
      drain_results();
      marker = shadow_line[TABLE_DEPTH] ^ 24'h1;
      if (marker == shadow_line[TABLE_DEPTH - 1])
         marker = marker ^ 24'h2;
      program_table(1'b1, COUNT_W'(TABLE_DEPTH), '1, marker);
      send_lookup(shadow_addr[TABLE_DEPTH - 1] + load_base, SLIDE_DOWN);
      send_next();
      send_next();
      send_next();
      send_lookup(shadow_addr[TABLE_DEPTH] + load_base, SLIDE_NONE);
      send_next();
   endtask

   // Cursor survives a spell with no table; zero count always misses
   task automatic test_cursor_hold();
      drain_results();
      program_table(1'b1, COUNT_W'(TABLE_DEPTH), '0, END_MARKER_RST);
      send_lookup(shadow_addr[10], SLIDE_DOWN);
      drain_results();
      program_table(1'b0, COUNT_W'(TABLE_DEPTH), '0, END_MARKER_RST);
      send_next();
      send_lookup(shadow_addr[10], SLIDE_DOWN);
      drain_results();
      program_table(1'b1, COUNT_W'(TABLE_DEPTH), '0, END_MARKER_RST);
      send_next();
      drain_results();
      program_table(1'b1, '0, '0, '0);
      send_lookup(shadow_addr[0], SLIDE_DOWN);
      send_lookup(shadow_addr[0], SLIDE_UP);
      send_next();
   endtask

   // Many short tables under random register settings, up to the item budget
   task automatic test_random_tables();
      int                 n, roll;
      logic [COUNT_W-1:0] count;
      logic [ADDR_W-1:0]  base;
      logic [LINE_W-1:0]  marker;
      bit                 present;
      while (items_sent < TOTAL_ITEMS) begin
         drain_results();
         gaps_on = ($urandom_range(0, 3) != 0);
         n       = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 40);
         roll    = $urandom_range(0, 19);
         if (roll == 0)
            count = COUNT_W'(TABLE_DEPTH);
         else if (roll == 1)
            count = '1;
         else if (roll == 2)
            count = COUNT_W'($urandom_range(TABLE_DEPTH + 1, 2046));
         else
            count = COUNT_W'(n);
         roll = $urandom_range(0, 9);
         base = (roll == 0) ? '0 : (roll == 1) ? '1 : $urandom;
         roll = $urandom_range(0, 9);
         marker  = (roll == 0) ? '0 : (roll == 1) ? END_MARKER_RST : LINE_W'($urandom);
         present = ($urandom_range(0, 9) != 0);
         program_table(present, count, base, marker);
         load_sorted_table(n, marker,
                           ($urandom_range(0, 3) == 0) ? '0 : $urandom_range(0, 32'h7FFF_FFFF),
                           1'b1);
         random_queries(n, $urandom_range(30, 90));
      end
   endtask

   // Each result strobe is one transfer; compare against the oldest answer
   always @(posedge clock) begin : check_answers
      line_answer_type want;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            $display("%0t: result expected none got line %0d addr %h span %h", $time,
                     rsp_line_number, rsp_statement_address, rsp_span_bytes);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_line_number !== want.line) begin
               mismatch_count++;
               $display("%0t: line_number expected %0d got %0d", $time,
                        $signed(want.line), rsp_line_number);
            end
            if (rsp_statement_address !== want.address) begin
               mismatch_count++;
               $display("%0t: statement_address expected %h got %h", $time,
                        want.address, rsp_statement_address);
            end
            if (rsp_span_bytes !== want.span) begin
               mismatch_count++;
               $display("%0t: span_bytes expected %h got %h", $time,
                        want.span, rsp_span_bytes);
            end
         end
      end
   end

   // Watchdog: too long without any transfer on any channel
   always @(posedge clock) begin
      if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_address_to_line_lookup failed");
            $finish;
         end
      end
   end

   initial begin
      cursor_at   = 0;
      cursor_live = 1'b1;
      tbl_present = 1'b0;
      tbl_count   = '0;
      load_base   = '0;
      end_marker  = END_MARKER_RST;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_full_table();
      test_past_storage();
      test_cursor_hold();
      test_random_tables();
      drain_results();
      if (mismatch_count == 0)
         $display("tb_address_to_line_lookup passed");
      else
         $display("tb_address_to_line_lookup failed");
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
rtl/a2l_pkg.sv
rtl/a2l_table_mem.sv
rtl/a2l_csr.sv
rtl/a2l_ctrl.sv
rtl/address_to_line_lookup.sv
sim/tb_address_to_line_lookup.sv
